[rtl/ipv4hc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header checker package
// Verdict codes, header constants and the result record shared by the
// capture logic and the top level.
// ----------------------------------------------------------------------------
package ipv4hc_pkg;

    typedef enum logic [3:0] {
        VERDICT_ICMP     = 4'd0,
        VERDICT_UDP      = 4'd1,
        VERDICT_TCP      = 4'd2,
        VERDICT_FRAGMENT = 4'd3,
        VERDICT_BAD_VER  = 4'd4,
        VERDICT_SHORT    = 4'd5,
        VERDICT_TTL_ZERO = 4'd6,
        VERDICT_BAD_SUM  = 4'd7,
        VERDICT_UNKNOWN  = 4'd8
    } verdict_t;

    localparam logic [3:0]  IP_VERSION    = 4'd4;
    localparam logic [3:0]  MIN_IHL       = 4'd5;
    localparam logic [15:0] SUM_GOOD      = 16'hffff;
    localparam logic [15:0] FRAG_MASK     = 16'h3fff;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;

    localparam logic [5:0]  POS_LEN_HI    = 6'd2;
    localparam logic [5:0]  POS_LEN_LO    = 6'd3;
    localparam logic [5:0]  POS_ID_HI     = 6'd4;
    localparam logic [5:0]  POS_ID_LO     = 6'd5;
    localparam logic [5:0]  POS_FRAG_HI   = 6'd6;
    localparam logic [5:0]  POS_FRAG_LO   = 6'd7;
    localparam logic [5:0]  POS_TTL       = 6'd8;
    localparam logic [5:0]  POS_PROTO     = 6'd9;
    localparam logic [5:0]  POS_SRC_FIRST = 6'd12;
    localparam logic [5:0]  POS_SRC_LAST  = 6'd15;
    localparam logic [5:0]  POS_DST_FIRST = 6'd16;
    localparam logic [5:0]  POS_DST_LAST  = 6'd19;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] payload_length;
        logic [15:0] datagram_id;
    } result_t;

endpackage

[rtl/ipv4hc_capture.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header capture
// Holds the per-datagram header state, folds the ones' complement sum and
// forms the verdict on the byte that completes or rejects a header.
// ----------------------------------------------------------------------------
module ipv4hc_capture
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_accept,
    input  logic [7:0]          header_byte,
    input  logic                start_of_datagram,
    output logic                result_valid,
    output ipv4hc_pkg::result_t result
);

    import ipv4hc_pkg::*;

    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  expected_reg, expected_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  pending_reg, pending_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] id_reg, id_next;
    logic [15:0] frag_reg, frag_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;
    logic        skip_reg, skip_next;

    logic [5:0]  cur_pos;
    logic [5:0]  cur_expected;
    logic [15:0] cur_sum;
    logic [7:0]  cur_pending;
    logic [7:0]  cur_ttl;
    logic [7:0]  cur_proto;
    logic [15:0] cur_total;
    logic [15:0] cur_id;
    logic [15:0] cur_frag;
    logic [31:0] cur_src;
    logic [31:0] cur_dst;

    logic        active;
    logic        first_byte;
    logic        bad_version;
    logic        short_header;
    logic        early;
    logic        done;
    logic [16:0] sum_wide;
    logic [6:0]  pos_plus_one;
    logic [15:0] header_len;
    logic [15:0] payload;
    verdict_t    final_verdict;

    always_comb
    begin
        active     = start_of_datagram || !skip_reg;
        cur_pos      = start_of_datagram ? 6'd0  : pos_reg;
        cur_expected = start_of_datagram ? 6'd0  : expected_reg;
        cur_sum      = start_of_datagram ? 16'd0 : sum_reg;
        cur_pending  = start_of_datagram ? 8'd0  : pending_reg;
        cur_ttl      = start_of_datagram ? 8'd0  : ttl_reg;
        cur_proto    = start_of_datagram ? 8'd0  : proto_reg;
        cur_total    = start_of_datagram ? 16'd0 : total_reg;
        cur_id       = start_of_datagram ? 16'd0 : id_reg;
        cur_frag     = start_of_datagram ? 16'd0 : frag_reg;
        cur_src      = start_of_datagram ? 32'd0 : src_reg;
        cur_dst      = start_of_datagram ? 32'd0 : dst_reg;

        first_byte   = (cur_pos == 6'd0);
        bad_version  = first_byte && (header_byte[7:4] != IP_VERSION);
        short_header = first_byte && !bad_version && (header_byte[3:0] < MIN_IHL);
        early        = bad_version || short_header;

        expected_next = first_byte ? {header_byte[3:0], 2'b00} : cur_expected;

        pending_next = cur_pending;
        sum_next     = cur_sum;
        sum_wide     = 17'd0;
        if (!cur_pos[0])
        begin
            pending_next = header_byte;
        end
        else
        begin
            sum_wide = {1'b0, cur_sum} + {1'b0, cur_pending, header_byte};
            sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
        end

        total_next = cur_total;
        id_next    = cur_id;
        frag_next  = cur_frag;
        ttl_next   = cur_ttl;
        proto_next = cur_proto;
        src_next   = cur_src;
        dst_next   = cur_dst;
        if (cur_pos == POS_LEN_HI)  total_next[15:8] = header_byte;
        if (cur_pos == POS_LEN_LO)  total_next[7:0]  = header_byte;
        if (cur_pos == POS_ID_HI)   id_next[15:8]    = header_byte;
        if (cur_pos == POS_ID_LO)   id_next[7:0]     = header_byte;
        if (cur_pos == POS_FRAG_HI) frag_next[15:8]  = header_byte;
        if (cur_pos == POS_FRAG_LO) frag_next[7:0]   = header_byte;
        if (cur_pos == POS_TTL)     ttl_next         = header_byte;
        if (cur_pos == POS_PROTO)   proto_next       = header_byte;
        if (cur_pos >= POS_SRC_FIRST && cur_pos <= POS_SRC_LAST)
        begin
            src_next = {cur_src[23:0], header_byte};
        end
        if (cur_pos >= POS_DST_FIRST && cur_pos <= POS_DST_LAST)
        begin
            dst_next = {cur_dst[23:0], header_byte};
        end

        pos_plus_one = {1'b0, cur_pos} + 7'd1;
        pos_next     = pos_plus_one[5:0];
        done         = !early && (pos_plus_one == {1'b0, expected_next});

        header_len = {10'd0, expected_next};
        payload    = (total_next > header_len) ? (total_next - header_len) : 16'd0;

        priority if (ttl_next == 8'd0)               final_verdict = VERDICT_TTL_ZERO;
        else if (sum_next != SUM_GOOD)               final_verdict = VERDICT_BAD_SUM;
        else if ((frag_next & FRAG_MASK) != 16'd0)   final_verdict = VERDICT_FRAGMENT;
        else if (proto_next == PROTO_ICMP)           final_verdict = VERDICT_ICMP;
        else if (proto_next == PROTO_UDP)            final_verdict = VERDICT_UDP;
        else if (proto_next == PROTO_TCP)            final_verdict = VERDICT_TCP;
        else                                         final_verdict = VERDICT_UNKNOWN;

        skip_next = done || early;

        result_valid = byte_accept && active && (early || done);
        if (early)
        begin
            result.verdict             = bad_version ? VERDICT_BAD_VER : VERDICT_SHORT;
            result.protocol_number     = cur_proto;
            result.source_address      = cur_src;
            result.destination_address = cur_dst;
            result.payload_length      = 16'd0;
            result.datagram_id         = cur_id;
        end
        else
        begin
            result.verdict             = final_verdict;
            result.protocol_number     = proto_next;
            result.source_address      = src_next;
            result.destination_address = dst_next;
            result.payload_length      = payload;
            result.datagram_id         = id_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 6'd0;
            expected_reg <= 6'd0;
            sum_reg      <= 16'd0;
            pending_reg  <= 8'd0;
            ttl_reg      <= 8'd0;
            proto_reg    <= 8'd0;
            total_reg    <= 16'd0;
            id_reg       <= 16'd0;
            frag_reg     <= 16'd0;
            src_reg      <= 32'd0;
            dst_reg      <= 32'd0;
            skip_reg     <= 1'b1;
        end
        else if (byte_accept && active)
        begin
            skip_reg <= skip_next;
            if (early)
            begin
                pos_reg      <= cur_pos;
                expected_reg <= cur_expected;
                sum_reg      <= cur_sum;
                pending_reg  <= cur_pending;
                ttl_reg      <= cur_ttl;
                proto_reg    <= cur_proto;
                total_reg    <= cur_total;
                id_reg       <= cur_id;
                frag_reg     <= cur_frag;
                src_reg      <= cur_src;
                dst_reg      <= cur_dst;
            end
            else
            begin
                pos_reg      <= pos_next;
                expected_reg <= expected_next;
                sum_reg      <= sum_next;
                pending_reg  <= pending_next;
                ttl_reg      <= ttl_next;
                proto_reg    <= proto_next;
                total_reg    <= total_next;
                id_reg       <= id_next;
                frag_reg     <= frag_next;
                src_reg      <= src_next;
                dst_reg      <= dst_next;
            end
        end
    end

endmodule

[rtl/ipv4_header_checker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header checker, top level
// Takes header bytes one transfer at a time and delivers one verdict per
// header through a registered output stream.
// ----------------------------------------------------------------------------
// The block accepts one header byte in every cycle in which it does not stall.
// A verdict is computed in the cycle of the byte that completes the header
// (or of the first byte when the version or header length is bad) and appears
// in the output register in the next cycle. The input side stalls only while
// that register holds a verdict that downstream does not take in the same cycle.
module ipv4_header_checker_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // header_byte [7:0]
    input  logic         s_tuser,   // start_of_datagram [0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // verdict [3:0], protocol_number [11:4], source_address [43:12],
    // destination_address [75:44], payload_length [91:76],
    // datagram_id [107:92], zero padding [111:108]
    output logic [111:0] m_tdata
);

    import ipv4hc_pkg::*;

    logic    byte_accept;
    logic    result_valid;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg, out_valid_next;

    assign s_tready    = !out_valid_reg || m_tready;
    assign byte_accept = s_tvalid && s_tready;

    ipv4hc_capture u_capture
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_accept       (byte_accept),
        .header_byte       (s_tdata),
        .start_of_datagram (s_tuser),
        .result_valid      (result_valid),
        .result            (result)
    );

    always_comb
    begin
        if (result_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0,
                       out_reg.datagram_id,
                       out_reg.payload_length,
                       out_reg.destination_address,
                       out_reg.source_address,
                       out_reg.protocol_number,
                       out_reg.verdict};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 header checker testbench
// Streams IPv4 header bytes into the checker, keeps its own model of the
// header capture, the ones' complement sum and the verdict order, and
// compares every verdict transfer with the oldest predicted one. Directed
// headers cover each verdict and the corner cases; random headers, broken
// headers and stray bytes follow, with random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb;

    import ipv4hc_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } hdr_byte_t;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;

    hdr_byte_t pending_bytes[$];
    result_t   expected_verdicts[$];
    int        failures  = 0;
    bit        fill_done = 1'b0;
    int        send_gap  = 0;
    int        recv_stall = 0;
    int        pushed_bytes = 0;

    logic [5:0]  hdr_pos;
    logic [5:0]  hdr_len;
    logic [16:0] csum;
    logic [7:0]  high_byte;
    logic [7:0]  ttl_q;
    logic [7:0]  proto_q;
    logic [15:0] tot_len_q;
    logic [15:0] id_q;
    logic [15:0] frag_q;
    logic [31:0] src_q;
    logic [31:0] dst_q;
    logic        skipping;

    ipv4_header_checker_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    function automatic void clear_header();
        hdr_pos   = '0;
        hdr_len   = '0;
        csum      = '0;
        high_byte = '0;
        ttl_q     = '0;
        proto_q   = '0;
        tot_len_q = '0;
        id_q      = '0;
        frag_q    = '0;
        src_q     = '0;
        dst_q     = '0;
    endfunction

    function automatic result_t make_verdict(input verdict_t v, input logic [15:0] pay);
        result_t r;
        r.verdict             = v;
        r.protocol_number     = proto_q;
        r.source_address      = src_q;
        r.destination_address = dst_q;
        r.payload_length      = pay;
        r.datagram_id         = id_q;
        skipping              = 1'b1;
        return r;
    endfunction

    function automatic bit predict_verdict(input logic [7:0] b, input logic start,
                                           output result_t r);
        logic [5:0]  pos;
        logic [15:0] pay;
        r = '0;
        if (start)
        begin
            clear_header();
            skipping = 1'b0;
        end
        else if (skipping)
        begin
            return 1'b0;
        end
        pos = hdr_pos;
        if (pos == 6'd0)
        begin
            if (b[7:4] != IP_VERSION)
            begin
                r = make_verdict(VERDICT_BAD_VER, 16'd0);
                return 1'b1;
            end
            if (b[3:0] < MIN_IHL)
            begin
                r = make_verdict(VERDICT_SHORT, 16'd0);
                return 1'b1;
            end
            hdr_len = {b[3:0], 2'b00};
        end
        if (!pos[0])
        begin
            high_byte = b;
        end
        else
        begin
            csum = csum + {1'b0, high_byte, b};
            csum = {1'b0, csum[15:0]} + {16'd0, csum[16]};
        end
        case (pos)
            POS_LEN_HI:  tot_len_q[15:8] = b;
            POS_LEN_LO:  tot_len_q[7:0]  = b;
            POS_ID_HI:   id_q[15:8]      = b;
            POS_ID_LO:   id_q[7:0]       = b;
            POS_FRAG_HI: frag_q[15:8]    = b;
            POS_FRAG_LO: frag_q[7:0]     = b;
            POS_TTL:     ttl_q           = b;
            POS_PROTO:   proto_q         = b;
            default:
            begin
                if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
                    src_q = {src_q[23:0], b};
                else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
                    dst_q = {dst_q[23:0], b};
            end
        endcase
        hdr_pos = pos + 6'd1;
        if ({1'b0, pos} + 7'd1 != {1'b0, hdr_len})
            return 1'b0;
        pay = (tot_len_q > {10'd0, hdr_len}) ? tot_len_q - {10'd0, hdr_len} : 16'd0;
        if (ttl_q == 8'd0)
            r = make_verdict(VERDICT_TTL_ZERO, pay);
        else if (csum[15:0] != SUM_GOOD)
            r = make_verdict(VERDICT_BAD_SUM, pay);
        else if ((frag_q & FRAG_MASK) != 16'd0)
            r = make_verdict(VERDICT_FRAGMENT, pay);
        else if (proto_q == PROTO_ICMP)
            r = make_verdict(VERDICT_ICMP, pay);
        else if (proto_q == PROTO_UDP)
            r = make_verdict(VERDICT_UDP, pay);
        else if (proto_q == PROTO_TCP)
            r = make_verdict(VERDICT_TCP, pay);
        else
            r = make_verdict(VERDICT_UNKNOWN, pay);
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        hdr_byte_t item;
        bit        quiet;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            quiet = fill_done && pending_bytes.size() < 200;
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_bytes.size() != 0)
            begin
                item = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.data;
                s_tuser  <= item.start;
                if (!quiet && $urandom_range(0, 15) == 0)
                    send_gap <= $urandom_range(1, 10);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        bit quiet;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            quiet = fill_done && pending_bytes.size() < 200;
            if (recv_stall != 0)
            begin
                m_tready   <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready   <= 1'b0;
                recv_stall <= $urandom_range(0, 9);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t next_verdict;
        if (!rst_n)
        begin
            clear_header();
            skipping = 1'b1;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("verdict transfer with no verdict expected: 0x%0h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("verdict", 32'(want.verdict), 32'(m_tdata[3:0]));
                    check_field("protocol_number", 32'(want.protocol_number),
                                32'(m_tdata[11:4]));
                    check_field("source_address", want.source_address, m_tdata[43:12]);
                    check_field("destination_address", want.destination_address,
                                m_tdata[75:44]);
                    check_field("payload_length", 32'(want.payload_length),
                                32'(m_tdata[91:76]));
                    check_field("datagram_id", 32'(want.datagram_id),
                                32'(m_tdata[107:92]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (predict_verdict(s_tdata, s_tuser, next_verdict))
                    expected_verdicts.push_back(next_verdict);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic start);
        hdr_byte_t item;
        item.data  = b;
        item.start = start;
        pending_bytes.push_back(item);
        pushed_bytes++;
    endtask

    task automatic send_noise(input int count);
        int i;
        for (i = 0; i < count; i++)
            push_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_header(input logic [3:0] ihl, input logic [15:0] tot_len,
                               input logic [15:0] id, input logic [15:0] frag,
                               input logic [7:0] ttl, input logic [7:0] proto,
                               input logic [31:0] src, input logic [31:0] dst,
                               input bit good_sum, input int keep);
        logic [7:0]  hdr [0:59];
        logic [16:0] acc;
        int          nbytes;
        int          i;
        nbytes = ihl * 4;
        for (i = 0; i < 60; i++)
            hdr[i] = 8'($urandom);
        hdr[0]  = {IP_VERSION, ihl};
        hdr[2]  = tot_len[15:8];
        hdr[3]  = tot_len[7:0];
        hdr[4]  = id[15:8];
        hdr[5]  = id[7:0];
        hdr[6]  = frag[15:8];
        hdr[7]  = frag[7:0];
        hdr[8]  = ttl;
        hdr[9]  = proto;
        {hdr[12], hdr[13], hdr[14], hdr[15]} = src;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
        if (good_sum)
        begin
            hdr[10] = 8'h00;
            hdr[11] = 8'h00;
            acc = '0;
            for (i = 0; i < nbytes; i += 2)
            begin
                acc = acc + {1'b0, hdr[i], hdr[i + 1]};
                acc = {1'b0, acc[15:0]} + {16'd0, acc[16]};
            end
            {hdr[10], hdr[11]} = ~acc[15:0];
        end
        for (i = 0; i < keep && i < nbytes; i++)
            push_byte(hdr[i], i == 0);
    endtask

    task automatic send_good(input logic [7:0] proto, input logic [15:0] frag);
        send_header(4'd5, 16'd64, 16'($urandom), frag, 8'd64, proto, $urandom, $urandom,
                    1'b1, 20);
    endtask

    task automatic wait_for_verdicts();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || s_tvalid);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int          sel;
        int          keep;
        logic [3:0]  ihl;
        logic [15:0] frag;
        logic [7:0]  proto;
        bit          paused;
        paused         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_noise(3);
        send_good(PROTO_UDP, 16'h0000);
        send_noise(2);
        send_good(PROTO_TCP, 16'h4000);
        send_good(PROTO_ICMP, 16'h0000);
        send_good(8'hff, 16'h0000);
        send_good(8'h00, 16'h0000);
        send_good(PROTO_UDP, 16'h2000);
        send_good(PROTO_TCP, 16'h0001);
        send_good(PROTO_TCP, 16'hffff);
        send_header(4'd5, 16'd40, 16'h1234, 16'h0000, 8'd0, PROTO_UDP, 32'h0a000001,
                    32'h0a000002, 1'b0, 20);
        send_header(4'd5, 16'd40, 16'h1234, 16'h0000, 8'd1, PROTO_UDP, 32'h0a000001,
                    32'h0a000002, 1'b0, 20);
        send_header(4'd15, 16'hffff, 16'hffff, 16'h0000, 8'hff, PROTO_TCP,
                    32'hffffffff, 32'hffffffff, 1'b1, 60);
        send_header(4'd6, 16'd0, 16'h0000, 16'h0000, 8'd1, PROTO_ICMP, 32'h0, 32'h0,
                    1'b1, 24);
        send_header(4'd5, 16'd20, 16'h8000, 16'h0000, 8'd128, PROTO_UDP,
                    32'hc0a80001, 32'h7f000001, 1'b1, 20);
        push_byte(8'h65, 1'b1);
        send_noise(3);
        push_byte(8'h05, 1'b1);
        push_byte(8'hff, 1'b1);
        push_byte(8'h44, 1'b1);
        push_byte(8'h40, 1'b1);
        send_noise(2);
        send_header(4'd5, 16'd100, 16'($urandom), 16'h0000, 8'd9, PROTO_UDP, $urandom,
                    $urandom, 1'b1, 10);
        send_header(4'd5, 16'd100, 16'($urandom), 16'h0000, 8'd9, PROTO_UDP, $urandom,
                    $urandom, 1'b1, 1);
        send_good(PROTO_UDP, 16'h0000);
        wait_for_verdicts();

        while (pushed_bytes < 750)
        begin
            sel = $urandom_range(0, 99);
            ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
            case ($urandom_range(0, 3))
                0:       frag = 16'($urandom);
                1:       frag = 16'h4000;
                default: frag = 16'h0000;
            endcase
            case ($urandom_range(0, 4))
                0:       proto = PROTO_ICMP;
                1:       proto = PROTO_UDP;
                2:       proto = PROTO_TCP;
                default: proto = 8'($urandom);
            endcase
            if (sel < 70)
            begin
                send_header(ihl, ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 1500)),
                            16'($urandom), frag,
                            ($urandom_range(0, 11) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                            proto, $urandom, $urandom, $urandom_range(0, 9) != 0, ihl * 4);
            end
            else if (sel < 80)
            begin
                sel = $urandom_range(0, 15);
                if (sel == 4)
                    push_byte({IP_VERSION, 4'($urandom_range(0, 4))}, 1'b1);
                else
                    push_byte({4'(sel), 4'($urandom)}, 1'b1);
                send_noise($urandom_range(0, 3));
            end
            else if (sel < 90)
            begin
                keep = $urandom_range(1, ihl * 4 - 1);
                send_header(ihl, 16'($urandom), 16'($urandom), frag, 8'($urandom), proto,
                            $urandom, $urandom, 1'b1, keep);
            end
            else
            begin
                send_noise($urandom_range(1, 4));
            end
            if (!paused && pushed_bytes >= 560)
            begin
                paused = 1'b1;
                wait_for_verdicts();
            end
        end
        fill_done = 1'b1;

        wait_for_verdicts();
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
